FILE: rtl/ssp_pkg.sv
`default_nettype none
package ssp_pkg;

  localparam int SQRT_LAT    = 32;
  localparam int DIV_LAT     = 64;
  localparam int MUL_LAT     = 3;
  localparam int FRONT_LAT   = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int QCNT_W      = 4;
  localparam int BACK_LAT    = SQRT_LAT + DIV_LAT + 2 * MUL_LAT + 3;

  localparam logic [47:0] RSQ_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_STRENGTH      = 2'd0,
    CFG_REST_DISTANCE = 2'd1,
    CFG_CUTOFF_SQ     = 2'd2,
    CFG_ENERGY_ENABLE = 2'd3
  } cfg_reg_t;

  // One classified pair as it crosses from the front to the back.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [47:0]      rsq;
    logic             in_range;
  } pair_word_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              nearly_full;
  } queue_status_t;

  typedef struct packed {
    logic [31:0] strength;
    logic [30:0] rest_distance;
    logic        energy_enable;
  } coef_t;

endpackage
`default_nettype wire

FILE: rtl/ssp_front.sv
`default_nettype none
module ssp_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic signed [COORD_WIDTH-1:0] delta_x,
  input  logic signed [COORD_WIDTH-1:0] delta_y,
  input  logic signed [COORD_WIDTH-1:0] delta_z,
  input  logic [47:0]                   cutoff_sq,
  output logic                          push,
  output ssp_pkg::pair_word_t           push_word
);
  import ssp_pkg::*;

  localparam int MW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;

  logic [2:0][COORD_WIDTH-1:0] raw;
  logic [2:0][COORD_WIDTH-1:0] mag_c;
  logic [2:0][MW-1:0]          ext_c;
  logic [2:0][31:0]            m_c;
  logic [2:0]                  neg_c;
  logic                        big_c;

  logic             v1, v2, v3;
  logic [2:0][31:0] f1_mag, f2_mag, f3_mag;
  logic [2:0]       f1_neg, f2_neg, f3_neg;
  logic             f1_big, f2_big, f3_big;
  logic [2:0][63:0] f2_sq;
  logic [49:0]      sum_hi;
  logic [17:0]      sum_lo;
  logic [49:0]      total;
  logic [47:0]      f3_rsq;

  assign raw = {delta_z, delta_y, delta_x};

  // Split each axis into sign and magnitude; flag any magnitude of 2^32 or more.
  always_comb begin
    big_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      neg_c[k] = raw[k][COORD_WIDTH-1];
      mag_c[k] = neg_c[k] ? (~raw[k] + COORD_WIDTH'(1)) : raw[k];
      ext_c[k] = MW'(mag_c[k]);
      m_c[k]   = ext_c[k][31:0];
      big_c    = big_c | ((ext_c[k] >> 32) != '0);
    end
  end

  always_comb begin
    sum_hi = 50'(f2_sq[0][63:16]) + 50'(f2_sq[1][63:16]) + 50'(f2_sq[2][63:16]);
    sum_lo = 18'(f2_sq[0][15:0]) + 18'(f2_sq[1][15:0]) + 18'(f2_sq[2][15:0]);
    total  = sum_hi + 50'(sum_lo[17:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    f1_mag <= m_c;
    f1_neg <= neg_c;
    f1_big <= big_c;
    for (int k = 0; k < 3; k++) begin
      f2_sq[k] <= 64'(f1_mag[k]) * 64'(f1_mag[k]);
    end
    f2_mag <= f1_mag;
    f2_neg <= f1_neg;
    f2_big <= f1_big;
    f3_rsq <= (total > 50'(RSQ_MAX)) ? RSQ_MAX : total[47:0];
    f3_mag <= f2_mag;
    f3_neg <= f2_neg;
    f3_big <= f2_big;
  end

  assign push               = v3;
  assign push_word.mag      = f3_mag;
  assign push_word.neg      = f3_neg;
  assign push_word.rsq      = f3_rsq;
  assign push_word.in_range = !f3_big && (f3_rsq < cutoff_sq) && (f3_rsq != '0);

endmodule
`default_nettype wire

FILE: rtl/ssp_queue.sv
`default_nettype none
module ssp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ssp_pkg::pair_word_t    push_word,
  output logic                   pop_valid,
  output ssp_pkg::pair_word_t    pop_word,
  output ssp_pkg::queue_status_t status
);
  import ssp_pkg::*;

  pair_word_t        slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  // The back takes a word every cycle one is there.
  assign pop       = (count != '0);
  assign pop_valid = pop;
  assign pop_word  = slot[rd_ptr];

  assign status.count       = count;
  assign status.nearly_full = (count >= QCNT_W'(QUEUE_DEPTH - FRONT_LAT));

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + QCNT_W'(1);
      2'b01:   count_next = count - QCNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue written while full");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0]))
    else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

FILE: rtl/ssp_sqrt.sv
`default_nettype none
module ssp_sqrt (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sqrt_stage_t;

  sqrt_stage_t stage   [SQRT_LAT];
  sqrt_stage_t step_in [SQRT_LAT];

  // One result bit per stage: bring down two radicand bits, try 4*root+1.
  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
    sqrt_stage_t o;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    rem_sh = {s.rem[33:0], s.rad[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    o.rad  = {s.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  assign step_in[0] = '{rem: '0, root: '0, rad: radicand};

  for (genvar i = 1; i < SQRT_LAT; i++) begin : g_link
    assign step_in[i] = stage[i-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQRT_LAT; i++) begin
      stage[i] <= sqrt_step(step_in[i]);
    end
  end

  assign root = stage[SQRT_LAT-1].root;

endmodule
`default_nettype wire

FILE: rtl/ssp_div.sv
`default_nettype none
module ssp_div (
  input  logic        clk,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] acc;
    logic [31:0] dsr;
  } div_stage_t;

  div_stage_t stage   [DIV_LAT];
  div_stage_t step_in [DIV_LAT];

  // Restoring step: shift one dividend bit out of acc, one quotient bit in.
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t o;
    logic [32:0] rs;
    logic [32:0] diff;
    rs    = {s.rem, s.acc[63]};
    diff  = rs - {1'b0, s.dsr};
    o.dsr = s.dsr;
    if (rs >= {1'b0, s.dsr}) begin
      o.rem = diff[31:0];
      o.acc = {s.acc[62:0], 1'b1};
    end else begin
      o.rem = rs[31:0];
      o.acc = {s.acc[62:0], 1'b0};
    end
    return o;
  endfunction

  assign step_in[0] = '{rem: '0, acc: dividend, dsr: divisor};

  for (genvar i = 1; i < DIV_LAT; i++) begin : g_link
    assign step_in[i] = stage[i-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_LAT; i++) begin
      stage[i] <= div_step(step_in[i]);
    end
  end

  assign quotient = stage[DIV_LAT-1].acc;

endmodule
`default_nettype wire

FILE: rtl/ssp_mul.sv
`default_nettype none
module ssp_mul (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod
);

  logic [63:0]  pp00, pp01, pp10, pp11;
  logic [64:0]  mid;
  logic [127:0] lohi;

  // Four 32x32 partial products, then cross terms, then the final add.
  always_ff @(posedge clk) begin
    pp00 <= 64'(a[31:0])  * 64'(b[31:0]);
    pp01 <= 64'(a[31:0])  * 64'(b[63:32]);
    pp10 <= 64'(a[63:32]) * 64'(b[31:0]);
    pp11 <= 64'(a[63:32]) * 64'(b[63:32]);
    mid  <= 65'(pp01) + 65'(pp10);
    lohi <= {pp11, pp00};
    prod <= lohi + {31'd0, mid, 32'd0};
  end

endmodule
`default_nettype wire

FILE: rtl/ssp_back.sv
`default_nettype none
module ssp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  ssp_pkg::pair_word_t pop_word,
  input  ssp_pkg::coef_t      coef,
  output logic                done,
  output logic signed [31:0]  force_x,
  output logic signed [31:0]  force_y,
  output logic signed [31:0]  force_z,
  output logic signed [31:0]  pair_energy,
  output logic                in_range
);
  import ssp_pkg::*;

  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             in_range;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       in_range;
  } dv_side_t;

  typedef struct packed {
    logic [63:0]      wmag;
    logic             wneg;
    logic [2:0][31:0] umag;
    logic [2:0]       neg;
    logic             in_range;
  } w_side_t;

  typedef struct packed {
    logic       gsign;
    logic [2:0] neg;
    logic       in_range;
  } g_side_t;

  logic        sneg;
  logic [31:0] smag;
  logic [30:0] rest_eff;
  logic [63:0] h_prod;
  logic [38:0] hmag;

  logic       b0_valid;
  pair_word_t b0_word;

  logic [31:0]  root;
  sq_side_t     sq_side [SQRT_LAT];
  logic [63:0]  t_quo;
  logic [63:0]  u_quo [3];
  dv_side_t     dv_side [DIV_LAT];

  logic        wneg_c;
  logic [63:0] wmag_c;
  w_side_t     w_reg;
  w_side_t     m1_side [MUL_LAT];
  logic [127:0] g_prod, p_prod;

  logic        gsign_c, psign_c;
  logic [63:0] glim_c, plim_c, gmag_c, pmag_c;
  logic [63:0] g_mag, p_mag, g_wmag;
  logic [2:0][31:0] g_umag;
  g_side_t     g_reg;
  g_side_t     m2_side [MUL_LAT];
  logic [127:0] f_prod [3];
  logic [127:0] e_prod;

  logic [2:0][31:0] force_c;
  logic [31:0]      energy_c;
  logic [BACK_LAT-1:0] vpipe;

  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? (32'd0 - mag[31:0]) : mag[31:0];
  endfunction

  // Coefficient terms that depend only on configuration.
  assign sneg     = coef.strength[31];
  assign smag     = sneg ? (~coef.strength + 32'd1) : coef.strength;
  assign rest_eff = (coef.rest_distance == '0) ? 31'd1 : coef.rest_distance;
  assign h_prod   = 64'(smag) * 64'(rest_eff);

  always_ff @(posedge clk) begin
    hmag <= h_prod[62:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
      vpipe    <= '0;
    end else begin
      b0_valid <= pop_valid;
      vpipe    <= {vpipe[BACK_LAT-2:0], b0_valid};
    end
  end

  always_ff @(posedge clk) begin
    b0_word <= pop_word;
  end

  ssp_sqrt u_sqrt (
    .clk      (clk),
    .radicand ({b0_word.rsq, 16'd0}),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    sq_side[0] <= {b0_word.mag, b0_word.neg, b0_word.in_range};
    for (int i = 1; i < SQRT_LAT; i++) begin
      sq_side[i] <= sq_side[i-1];
    end
  end

  ssp_div u_div_t (
    .clk      (clk),
    .dividend ({root, 32'd0}),
    .divisor  ({1'b0, rest_eff}),
    .quotient (t_quo)
  );

  for (genvar k = 0; k < 3; k++) begin : g_unit
    ssp_div u_div_u (
      .clk      (clk),
      .dividend ({2'b00, sq_side[SQRT_LAT-1].mag[k], 30'd0}),
      .divisor  (root),
      .quotient (u_quo[k])
    );
  end

  always_ff @(posedge clk) begin
    dv_side[0] <= {sq_side[SQRT_LAT-1].neg, sq_side[SQRT_LAT-1].in_range};
    for (int i = 1; i < DIV_LAT; i++) begin
      dv_side[i] <= dv_side[i-1];
    end
  end

  assign wneg_c = (t_quo > ONE_Q32);
  assign wmag_c = wneg_c ? (t_quo - ONE_Q32) : (ONE_Q32 - t_quo);

  always_ff @(posedge clk) begin
    w_reg.wmag     <= wmag_c;
    w_reg.wneg     <= wneg_c;
    w_reg.umag     <= {u_quo[2][31:0], u_quo[1][31:0], u_quo[0][31:0]};
    w_reg.neg      <= dv_side[DIV_LAT-1].neg;
    w_reg.in_range <= dv_side[DIV_LAT-1].in_range;
  end

  ssp_mul u_mul_g (
    .clk  (clk),
    .a    ({32'd0, smag}),
    .b    (w_reg.wmag),
    .prod (g_prod)
  );

  ssp_mul u_mul_p (
    .clk  (clk),
    .a    ({25'd0, hmag}),
    .b    (w_reg.wmag),
    .prod (p_prod)
  );

  always_ff @(posedge clk) begin
    m1_side[0] <= w_reg;
    for (int i = 1; i < MUL_LAT; i++) begin
      m1_side[i] <= m1_side[i-1];
    end
  end

  // Shift by 32 and clip each magnitude to the signed 64-bit range.
  always_comb begin
    gsign_c = sneg ^ m1_side[MUL_LAT-1].wneg;
    psign_c = sneg ^ m1_side[MUL_LAT-1].wneg;
    glim_c  = gsign_c ? NEG_LIM : POS_LIM;
    plim_c  = psign_c ? NEG_LIM : POS_LIM;
    gmag_c  = (g_prod[127:32] > 96'(glim_c)) ? glim_c : g_prod[95:32];
    pmag_c  = (p_prod[127:32] > 96'(plim_c)) ? plim_c : p_prod[95:32];
  end

  always_ff @(posedge clk) begin
    g_mag          <= gmag_c;
    p_mag          <= pmag_c;
    g_wmag         <= m1_side[MUL_LAT-1].wmag;
    g_umag         <= m1_side[MUL_LAT-1].umag;
    g_reg.gsign    <= gsign_c;
    g_reg.neg      <= m1_side[MUL_LAT-1].neg;
    g_reg.in_range <= m1_side[MUL_LAT-1].in_range;
  end

  for (genvar k = 0; k < 3; k++) begin : g_force
    ssp_mul u_mul_f (
      .clk  (clk),
      .a    (g_mag),
      .b    ({32'd0, g_umag[k]}),
      .prod (f_prod[k])
    );
  end

  ssp_mul u_mul_e (
    .clk  (clk),
    .a    (p_mag),
    .b    (g_wmag),
    .prod (e_prod)
  );

  always_ff @(posedge clk) begin
    m2_side[0] <= g_reg;
    for (int i = 1; i < MUL_LAT; i++) begin
      m2_side[i] <= m2_side[i-1];
    end
  end

  // Energy carries the sign of strength; the 33 folds in the half.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      force_c[k] = m2_side[MUL_LAT-1].in_range
                 ? clamp32(m2_side[MUL_LAT-1].gsign ^ m2_side[MUL_LAT-1].neg[k],
                           f_prod[k] >> 30)
                 : 32'd0;
    end
    energy_c = (m2_side[MUL_LAT-1].in_range && coef.energy_enable)
             ? clamp32(sneg, e_prod >> 33) : 32'd0;
  end

  always_ff @(posedge clk) begin
    force_x     <= force_c[0];
    force_y     <= force_c[1];
    force_z     <= force_c[2];
    pair_energy <= energy_c;
    in_range    <= m2_side[MUL_LAT-1].in_range;
  end

  assign done = vpipe[BACK_LAT-1];

  a_quiet_out: assert property (@(posedge clk) disable iff (rst)
    done && !in_range |-> (force_x == 0) && (force_y == 0) && (force_z == 0)
                          && (pair_energy == 0))
    else $error("out of range pair gave a nonzero result");

  a_energy_off: assert property (@(posedge clk) disable iff (rst)
    done && !coef.energy_enable |-> (pair_energy == 0))
    else $error("energy reported while disabled");

endmodule
`default_nettype wire

FILE: rtl/soft_spring_pair_force.sv
`default_nettype none
// Soft-spring pair force engine. Give it one atom pair's displacement
// (delta_x/y/z, signed Q8.24) by raising start in a cycle where busy is low;
// it returns the Q16.16 force on atom i, the pair energy when energy_enable
// is set, and in_range, all together in the single cycle where done is high.
// The engine accepts a new pair in every cycle that busy is low, and the
// results come out in the order the pairs came in. Each pair passes through
// the square-root pipeline (32 stages, one root bit each), then the long
// dividers (64 stages, one quotient bit each) and two rounds of split
// 64-bit multipliers. done is a strobe: results cannot be held off, so
// capture them in the cycle they appear. Pairs at or beyond the cutoff, or
// at zero distance, come back with in_range low and all other outputs zero.
// Write configuration through the cfg port (always ready) only while no
// pair is in flight; the registers reset to strength 1.0, rest distance
// 1.0, cutoff_sq 1.0 and energy off.
module soft_spring_pair_force #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] delta_x,
  input  logic signed [COORD_WIDTH-1:0] delta_y,
  input  logic signed [COORD_WIDTH-1:0] delta_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ssp_pkg::cfg_reg_t             cfg_index,
  input  logic [47:0]                   cfg_data,
  output logic                          done,
  output logic signed [31:0]            force_x,
  output logic signed [31:0]            force_y,
  output logic signed [31:0]            force_z,
  output logic signed [31:0]            pair_energy,
  output logic                          in_range
);
  import ssp_pkg::*;

  logic [31:0] strength;
  logic [30:0] rest_distance;
  logic [47:0] cutoff_sq;
  logic        energy_enable;

  logic          take;
  logic          push;
  pair_word_t    push_word;
  logic          pop_valid;
  pair_word_t    pop_word;
  queue_status_t q_status;
  coef_t         coef;

  // Configuration registers: always ready, written on valid.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength      <= 32'h0001_0000;
      rest_distance <= 31'h0100_0000;
      cutoff_sq     <= 48'h0001_0000_0000;
      energy_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STRENGTH:      strength      <= cfg_data[31:0];
        CFG_REST_DISTANCE: rest_distance <= cfg_data[30:0];
        CFG_CUTOFF_SQ:     cutoff_sq     <= cfg_data;
        CFG_ENERGY_ENABLE: energy_enable <= cfg_data[0];
      endcase
    end
  end

  // Hold off new pairs only when the queue could not absorb the front's
  // in-flight words; with the back draining every cycle this never happens.
  assign busy = q_status.nearly_full;
  assign take = start && !busy;

  assign coef.strength      = strength;
  assign coef.rest_distance = rest_distance;
  assign coef.energy_enable = energy_enable;

  // Front: magnitudes, squares, squared distance, cutoff test.
  ssp_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .delta_x   (delta_x),
    .delta_y   (delta_y),
    .delta_z   (delta_z),
    .cutoff_sq (cutoff_sq),
    .push      (push),
    .push_word (push_word)
  );

  // Short queue decoupling front and back.
  ssp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop_valid (pop_valid),
    .pop_word  (pop_word),
    .status    (q_status)
  );

  // Back: root, weight, unit vector, force and energy.
  ssp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_word    (pop_word),
    .coef        (coef),
    .done        (done),
    .force_x     (force_x),
    .force_y     (force_y),
    .force_z     (force_z),
    .pair_energy (pair_energy),
    .in_range    (in_range)
  );

endmodule
`default_nettype wire

FILE: tb/sv/soft_spring_pair_force_tb.sv
`default_nettype none
module soft_spring_pair_force_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssp_pkg::*;

  localparam int PIPE_LAT   = 110;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [31:0] energy;
    logic               hit;
  } force_t;

  logic clk, rst;
  logic start, busy;
  logic signed [31:0] delta_x, delta_y, delta_z;
  logic cfg_valid, cfg_ready;
  cfg_reg_t cfg_index;
  logic [47:0] cfg_data;
  logic done;
  logic signed [31:0] force_x, force_y, force_z, pair_energy;
  logic in_range;

  soft_spring_pair_force uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .delta_x(delta_x), .delta_y(delta_y), .delta_z(delta_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .pair_energy(pair_energy), .in_range(in_range)
  );

  // Predictor copy of the coefficient registers.
  logic [31:0] k_strength;
  logic [30:0] k_rest;
  logic [47:0] k_cutoff;
  logic        k_energy_on;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  int     errors, checked, hits, stall;
  bit     pairs_done;
  bit     no_idle;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // (neg ? -1 : 1) * (a*b >> s), saturated to the signed 64-bit range
  function automatic logic signed [63:0] mul_shift(bit neg, logic [63:0] a,
                                                   logic [63:0] b, int s);
    logic [127:0] prod;
    logic [127:0] sh;
    logic [63:0]  lim;
    prod = a * b;
    sh = prod >> s;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (sh > {64'd0, lim}) sh = {64'd0, lim};
    return neg ? -$signed(sh[63:0]) : $signed(sh[63:0]);
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic force_t pair_force(pair_t p);
    force_t o;
    logic [31:0] d[3];
    logic [63:0] m[3];
    bit          n[3];
    logic [65:0] sumsq;
    logic [63:0] rsq, r, e, t, wmag, smag, umag;
    bit          wneg, sneg;
    logic signed [63:0] g, h, pe, en;
    o = '0;
    d[0] = p.dx; d[1] = p.dy; d[2] = p.dz;
    sumsq = 0;
    for (int k = 0; k < 3; k++) begin
      n[k] = d[k][31];
      m[k] = n[k] ? {32'd0, -d[k]} : {32'd0, d[k]};
      sumsq += m[k] * m[k];
    end
    // floor of the exact sum equals the split-sum form
    rsq = sumsq >> 16;
    if (rsq > 64'hFFFF_FFFF_FFFF) rsq = 64'hFFFF_FFFF_FFFF;
    if (!(rsq < {16'd0, k_cutoff}) || rsq == 0) return o;
    r = root64(rsq << 16);
    e = (k_rest == 0) ? 64'd1 : {33'd0, k_rest};
    t = ({64'd0, r} << 32) / e;
    wneg = t > 64'h1_0000_0000;
    wmag = wneg ? t - 64'h1_0000_0000 : 64'h1_0000_0000 - t;
    sneg = k_strength[31];
    smag = sneg ? {32'd0, -k_strength} : {32'd0, k_strength};
    g = mul_shift(sneg != wneg, smag, wmag, 32);
    for (int k = 0; k < 3; k++) begin
      umag = (m[k] << 30) / r;
      d[k] = clamp32(mul_shift((g < 0) != n[k], mag64(g), umag, 30));
    end
    o.fx = d[0]; o.fy = d[1]; o.fz = d[2];
    if (k_energy_on) begin
      h = mul_shift(sneg, smag, e, 24);
      pe = mul_shift((h < 0) != wneg, mag64(h), wmag, 32);
      en = mul_shift((pe < 0) != wneg, mag64(pe), wmag, 33);
      o.energy = clamp32(en);
    end
    o.hit = 1'b1;
    return o;
  endfunction

  // Driver: present the next pending pair, idle at random.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_forces.push_back(pair_force({delta_x, delta_y, delta_z}));
        void'(pending_pairs.pop_front());
      end
      // what is left after a possible pop this edge
      if (pending_pairs.size() > (start && !busy ? 0 : 0) &&
          !(start && !busy && pending_pairs.size() == 0) &&
          (no_idle || $urandom_range(99) >= 37)) begin
        start   <= 1'b1;
        delta_x <= pending_pairs[0].dx;
        delta_y <= pending_pairs[0].dy;
        delta_z <= pending_pairs[0].dz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    force_t want;
    if (!rst && done) begin
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected result fx=%0d fy=%0d fz=%0d e=%0d hit=%0b",
                 $time, force_x, force_y, force_z, pair_energy, in_range);
        errors++;
      end else begin
        want = expected_forces.pop_front();
        checked++;
        if (want.hit) hits++;
        if (force_x !== want.fx || force_y !== want.fy || force_z !== want.fz ||
            pair_energy !== want.energy || in_range !== want.hit) begin
          $display("%0t: mismatch exp fx=%0d fy=%0d fz=%0d e=%0d hit=%0b",
                   $time, want.fx, want.fy, want.fz, want.energy, want.hit);
          $display("%0t:          got fx=%0d fy=%0d fz=%0d e=%0d hit=%0b",
                   $time, force_x, force_y, force_z, pair_energy, in_range);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall <= 0;
    else stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_forces.size());
      $display("soft_spring_pair_force_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STRENGTH:      k_strength  = value[31:0];
      CFG_REST_DISTANCE: k_rest      = value[30:0];
      CFG_CUTOFF_SQ:     k_cutoff    = value;
      default:           k_energy_on = value[0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_coefs(logic [31:0] s, logic [30:0] rd, logic [47:0] c, bit en);
    write_reg(CFG_STRENGTH, {16'd0, s});
    write_reg(CFG_REST_DISTANCE, {17'd0, rd});
    write_reg(CFG_CUTOFF_SQ, c);
    write_reg(CFG_ENERGY_ENABLE, {47'd0, en});
  endtask

  // Wait for the pipeline to drain, then let it settle.
  task automatic drain();
    while (pending_pairs.size() != 0 || start || expected_forces.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_delta(logic [31:0] span);
    logic [31:0] v;
    v = $urandom_range(span);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random pairs, mostly within about the cutoff radius so most land in range.
  task automatic queue_random(int count, logic [31:0] span);
    pair_t p;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       p = {$urandom, $urandom, $urandom};
        1:       p = {rand_delta(span), 32'd0, 32'd0};
        default: p = {rand_delta(span), rand_delta(span), rand_delta(span)};
      endcase
      pending_pairs.push_back(p);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    delta_x = '0; delta_y = '0; delta_z = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STRENGTH;
    cfg_data = '0;
    errors = 0; checked = 0; hits = 0;
    no_idle = 1'b0;
    k_strength = 32'h0001_0000;
    k_rest = 31'h0100_0000;
    k_cutoff = 48'h1_0000_0000;
    k_energy_on = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero distance, extremes, near and at the cutoff, axis pairs.
    set_coefs(32'h0001_0000, 31'h0100_0000, 48'h1_0000_0000, 1'b1);
    pending_pairs.push_back('{32'd0, 32'd0, 32'd0});
    pending_pairs.push_back('{32'd1, 32'd0, 32'd0});
    pending_pairs.push_back('{-32'sd1, 32'd0, 32'd0});
    pending_pairs.push_back('{32'h0100_0000, 32'd0, 32'd0});
    pending_pairs.push_back('{32'h00FF_FFFF, 32'd0, 32'd0});
    pending_pairs.push_back('{32'h0080_0000, -32'sh0040_0000, 32'h0020_0000});
    pending_pairs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pairs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_pairs.push_back('{32'h0000_0100, -32'sh0000_0100, 32'h0000_0001});
    drain();
    // Widest cutoff, largest strength and tiny rest distance: saturation.
    set_coefs(32'h7FFF_FFFF, 31'd1, 48'hFFFF_FFFF_FFFF, 1'b1);
    pending_pairs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pairs.push_back('{32'h8000_0000, 32'd5, -32'sd5});
    pending_pairs.push_back('{32'd1, 32'd1, 32'd1});
    pending_pairs.push_back('{-32'sh0300_0000, 32'h0200_0000, 32'd0});
    drain();
    // Most negative strength, largest rest distance, zero rest distance, zero cutoff.
    set_coefs(32'h8000_0000, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    pending_pairs.push_back('{32'h0100_0000, 32'h0100_0000, 32'd0});
    pending_pairs.push_back('{32'h7FFF_FFFF, -32'sd7, 32'h8000_0000});
    drain();
    set_coefs(32'h0002_8000, 31'd0, 48'd0, 1'b0);
    pending_pairs.push_back('{32'h0000_1000, 32'd0, 32'd0});
    pending_pairs.push_back('{32'd0, 32'd0, 32'd0});
    drain();

    // Random phases over several coefficient settings.
    for (int ph = 0; ph < 6; ph++) begin
      set_coefs($urandom, 31'($urandom_range(31'h7FFF_FFFF, 31'h0000_1000)),
                48'({$urandom, $urandom}), 1'($urandom_range(1)));
      // pick a cutoff that the random radius actually straddles
      write_reg(CFG_CUTOFF_SQ, 48'h1_0000_0000 << $urandom_range(14));
      no_idle = (ph == 2);
      queue_random(190, 32'h0100_0000 << $urandom_range(6));
      drain();
    end
    set_coefs(32'h0001_0000, 31'h0100_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
    queue_random(40, 32'h7FFF_FFFF);
    drain();

    $display("covered %0d pairs, %0d within cutoff, over 11 coefficient settings",
             checked, hits);
    if (errors == 0) begin
      $display("soft_spring_pair_force_tb: done, clean");
    end else begin
      $display("soft_spring_pair_force_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: soft_spring_pair_force.f
rtl/ssp_pkg.sv
rtl/ssp_front.sv
rtl/ssp_queue.sv
rtl/ssp_sqrt.sv
rtl/ssp_div.sv
rtl/ssp_mul.sv
rtl/ssp_back.sv
rtl/soft_spring_pair_force.sv
tb/sv/soft_spring_pair_force_tb.sv
